[rtl/drpt_pkg.sv]
// shared types and constants of the decimal residue prime test block
package drpt_pkg;

   localparam int DIGIT_W   = 4;
   localparam int RESIDUE_W = 32;
   localparam int CSR_W     = 32;

   localparam logic [CSR_W-1:0] MODULUS_RESET = 32'd1000000007;

   // digit fold: 10*r+d < 32*n, so subtract n<<4 down to n<<0
   localparam int                 RED_CNT_W     = 3;
   localparam logic [RED_CNT_W-1:0] RED_SHIFT_TOP = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FOLD,
      ST_LOAD,
      ST_REDUCE,
      ST_CHECK,
      ST_STRIP,
      ST_EXP_STEP,
      ST_MUL_DBL,
      ST_MUL_ADD,
      ST_MUL_END,
      ST_XCHECK,
      ST_EMIT
   } phase_type;

   typedef enum logic [1:0] {
      MUL_PROD,
      MUL_BASE,
      MUL_SQ
   } mul_op_type;

endpackage

[rtl/drpt_if.sv]
// valid/ready channel interfaces for digits, results and the modulus register
interface drpt_req_if;
   import drpt_pkg::*;
   logic               valid;
   logic               ready;
   logic [DIGIT_W-1:0] digit;
   logic               last;
   modport source (output valid, output digit, output last, input ready);
   modport sink (input valid, input digit, input last, output ready);
endinterface

interface drpt_rsp_if;
   import drpt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [RESIDUE_W-1:0] residue;
   logic                 is_prime;
   modport source (output valid, output residue, output is_prime, input ready);
   modport sink (input valid, input residue, input is_prime, output ready);
endinterface

interface drpt_csr_if;
   import drpt_pkg::*;
   logic             valid;
   logic             ready;
   logic [CSR_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/drpt_addmod.sv]
// shared add and conditional subtract unit: z = x+y, minus m when that sum reaches m
module drpt_addmod #(
   parameter int WIDTH = 36
) (
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic [WIDTH-1:0] m,
   output logic [WIDTH-1:0] z
);

   logic [WIDTH:0] sum;
   logic [WIDTH:0] diff;
   logic           ge;

   assign sum  = {1'b0, x} + {1'b0, y};
   assign ge   = (sum >= {1'b0, m});
   assign diff = sum - {1'b0, m};
   assign z    = ge ? diff[WIDTH-1:0] : sum[WIDTH-1:0];

endmodule

[rtl/decimal_residue_prime_test_unit.sv]
// top level: decimal digit residue reduction and base-2 strong probable-prime test
//
// Digits arrive one beat at a time, most significant first, and the block keeps
// (residue*10 + digit) mod modulus, with a modulus of zero acting as one. A
// digit beat is taken, residue*10+digit is formed and five compare-subtract
// steps run against modulus<<4 down to modulus<<0. If the stored residue is
// not below the modulus (the register was rewritten in the middle of a
// number) it is first folded bit by bit.
// The beat marked last starts the test on the residue n: values up to 4 are
// settled at once; otherwise n-1 = d*2^r is found one shift a cycle, 2^d mod n
// runs by square-and-multiply, and up to r-1 squarings follow. Each modular
// multiply is MSB-first shift-and-add on the one shared add/subtract unit,
// and a test needs at most about 2*MOD_WIDTH multiplies. The input is not
// ready while a number's digit or test is in progress. One result beat per
// number sits in an output register; a finished test waits only if the
// previous result has not been taken, and new digits are taken while a result
// waits. The modulus register is written on its own channel; the user must
// write it only while no digit or test is in progress, since the block
// itself does not enforce this.
module decimal_residue_prime_test_unit #(
   parameter int MOD_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   drpt_req_if.sink   req_port,
   drpt_rsp_if.source rsp_port,
   drpt_csr_if.sink   csr_port
);
   import drpt_pkg::*;

   // value width during a digit step: 10*(2^W-1)+15 < 2^(W+4)
   localparam int VW = MOD_WIDTH + 4;
   localparam int BW = $clog2(MOD_WIDTH);
   localparam int RW = $clog2(MOD_WIDTH);

   // control state
   phase_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // configuration and architectural residue
   logic [MOD_WIDTH-1:0] modulus_ff, modulus_in;
   logic [MOD_WIDTH-1:0] resid_ff, resid_in;

   // digit step
   logic [DIGIT_W-1:0]   digit_ff, digit_in;
   logic                 last_ff, last_in;
   logic [VW-1:0]        val_ff, val_in;
   logic [RED_CNT_W-1:0] red_cnt_ff, red_cnt_in;

   // primality test
   logic [MOD_WIDTH-1:0] n_ff, n_in;
   logic [MOD_WIDTH-1:0] exp_ff, exp_in;
   logic [RW-1:0]        r_ff, r_in;
   logic [MOD_WIDTH-1:0] base_ff, base_in;
   logic [MOD_WIDTH-1:0] prod_ff, prod_in;
   logic                 prime_ff, prime_in;

   // shift-and-add multiplier sequencing
   logic [MOD_WIDTH-1:0] acc_ff, acc_in;
   logic [MOD_WIDTH-1:0] mul_a_ff, mul_a_in;
   logic [MOD_WIDTH-1:0] mul_b_ff, mul_b_in;
   logic [BW-1:0]        bit_cnt_ff, bit_cnt_in;
   mul_op_type           mul_op_ff, mul_op_in;

   // result register
   logic [MOD_WIDTH-1:0] rsp_residue_ff, rsp_residue_in;
   logic                 rsp_prime_ff, rsp_prime_in;

   // shared unit
   logic [VW-1:0] unit_x, unit_y, unit_m, unit_z;

   // handy terms
   logic [MOD_WIDTH-1:0] nm;
   logic [MOD_WIDTH-1:0] n_minus1;
   logic                 req_fire;
   logic                 emit_free;
   logic                 bit_last;
   logic                 mul_top;
   logic                 few_sq;

   assign nm        = (modulus_ff == '0) ? MOD_WIDTH'(1) : modulus_ff;
   assign n_minus1  = n_ff - MOD_WIDTH'(1);
   assign req_fire  = req_port.valid && (state_ff == ST_IDLE);
   assign emit_free = !rsp_valid_ff || rsp_port.ready;
   assign bit_last  = (bit_cnt_ff == '0);
   assign mul_top   = mul_b_ff[MOD_WIDTH-1];
   assign few_sq    = (r_ff <= RW'(1));

   // ports
   assign req_port.ready    = (state_ff == ST_IDLE);
   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.residue  = RESIDUE_W'(rsp_residue_ff);
   assign rsp_port.is_prime = rsp_prime_ff;
   assign csr_port.ready    = 1'b1;

   // operand selection for the shared add/subtract unit
   always_comb begin
      case (state_ff)
         ST_FOLD: begin
            // 2*acc + next bit, acc < n so one subtract is enough
            unit_x = VW'({acc_ff, mul_b_ff[MOD_WIDTH-1]});
            unit_y = '0;
            unit_m = VW'(nm);
         end
         ST_REDUCE: begin
            unit_x = val_ff;
            unit_y = '0;
            unit_m = VW'(nm) << red_cnt_ff;
         end
         ST_MUL_ADD: begin
            unit_x = VW'(acc_ff);
            unit_y = VW'(mul_a_ff);
            unit_m = VW'(n_ff);
         end
         default: begin
            // doubling step of the multiplier
            unit_x = VW'(acc_ff);
            unit_y = VW'(acc_ff);
            unit_m = VW'(n_ff);
         end
      endcase
   end

   drpt_addmod #(
      .WIDTH (VW)
   ) u_addmod (
      .x (unit_x),
      .y (unit_y),
      .m (unit_m),
      .z (unit_z)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (resid_ff >= nm) ? ST_FOLD : ST_LOAD;
            end
         end
         ST_FOLD: begin
            if (bit_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_REDUCE;
         ST_REDUCE: begin
            if (red_cnt_ff == '0) begin
               state_in = last_ff ? ST_CHECK : ST_IDLE;
            end
         end
         ST_CHECK: state_in = (n_ff <= MOD_WIDTH'(4)) ? ST_EMIT : ST_STRIP;
         ST_STRIP: begin
            if (exp_ff[0]) begin
               state_in = ST_EXP_STEP;
            end
         end
         ST_EXP_STEP: state_in = (exp_ff == '0) ? ST_XCHECK : ST_MUL_DBL;
         ST_MUL_DBL: begin
            if (mul_top) begin
               state_in = ST_MUL_ADD;
            end else if (bit_last) begin
               state_in = ST_MUL_END;
            end
         end
         ST_MUL_ADD: state_in = bit_last ? ST_MUL_END : ST_MUL_DBL;
         ST_MUL_END: begin
            case (mul_op_ff)
               MUL_PROD: state_in = (exp_ff[MOD_WIDTH-1:1] == '0) ? ST_XCHECK : ST_MUL_DBL;
               MUL_BASE: state_in = ST_EXP_STEP;
               MUL_SQ:   state_in = (acc_ff == n_minus1 || few_sq) ? ST_EMIT : ST_MUL_DBL;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_XCHECK: begin
            if (prod_ff == MOD_WIDTH'(1) || prod_ff == n_minus1 || few_sq) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL_DBL;
            end
         end
         ST_EMIT: begin
            if (emit_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      modulus_in     = modulus_ff;
      resid_in       = resid_ff;
      digit_in       = digit_ff;
      last_in        = last_ff;
      val_in         = val_ff;
      red_cnt_in     = red_cnt_ff;
      n_in           = n_ff;
      exp_in         = exp_ff;
      r_in           = r_ff;
      base_in        = base_ff;
      prod_in        = prod_ff;
      prime_in       = prime_ff;
      acc_in         = acc_ff;
      mul_a_in       = mul_a_ff;
      mul_b_in       = mul_b_ff;
      bit_cnt_in     = bit_cnt_ff;
      mul_op_in      = mul_op_ff;
      rsp_residue_in = rsp_residue_ff;
      rsp_prime_in   = rsp_prime_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_port.ready;

      if (csr_port.valid) begin
         modulus_in = csr_port.data[MOD_WIDTH-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               digit_in   = req_port.digit;
               last_in    = req_port.last;
               // fold setup, used only when the residue is out of range
               acc_in     = '0;
               mul_b_in   = resid_ff;
               bit_cnt_in = BW'(MOD_WIDTH - 1);
            end
         end
         ST_FOLD: begin
            acc_in     = unit_z[MOD_WIDTH-1:0];
            mul_b_in   = mul_b_ff << 1;
            bit_cnt_in = bit_cnt_ff - BW'(1);
            if (bit_last) begin
               resid_in = unit_z[MOD_WIDTH-1:0];
            end
         end
         ST_LOAD: begin
            // residue*10 + digit as two shifts and two adds
            val_in     = (VW'(resid_ff) << 3) + (VW'(resid_ff) << 1) + VW'(digit_ff);
            red_cnt_in = RED_SHIFT_TOP;
         end
         ST_REDUCE: begin
            val_in     = unit_z;
            red_cnt_in = red_cnt_ff - RED_CNT_W'(1);
            if (red_cnt_ff == '0) begin
               if (last_ff) begin
                  resid_in = '0;
                  n_in     = unit_z[MOD_WIDTH-1:0];
               end else begin
                  resid_in = unit_z[MOD_WIDTH-1:0];
               end
            end
         end
         ST_CHECK: begin
            // 2 and 3 are prime; 0, 1 and 4 are not
            prime_in = (n_ff == MOD_WIDTH'(2)) || (n_ff == MOD_WIDTH'(3));
            exp_in   = n_minus1;
            r_in     = '0;
         end
         ST_STRIP: begin
            if (!exp_ff[0]) begin
               exp_in = exp_ff >> 1;
               r_in   = r_ff + RW'(1);
            end else begin
               base_in = MOD_WIDTH'(2);
               prod_in = MOD_WIDTH'(1);
            end
         end
         ST_EXP_STEP: begin
            if (exp_ff != '0) begin
               acc_in     = '0;
               bit_cnt_in = BW'(MOD_WIDTH - 1);
               if (exp_ff[0]) begin
                  mul_a_in  = prod_ff;
                  mul_b_in  = base_ff;
                  mul_op_in = MUL_PROD;
               end else begin
                  exp_in    = exp_ff >> 1;
                  mul_a_in  = base_ff;
                  mul_b_in  = base_ff;
                  mul_op_in = MUL_BASE;
               end
            end
         end
         ST_MUL_DBL: begin
            acc_in = unit_z[MOD_WIDTH-1:0];
            if (!mul_top) begin
               mul_b_in   = mul_b_ff << 1;
               bit_cnt_in = bit_cnt_ff - BW'(1);
            end
         end
         ST_MUL_ADD: begin
            acc_in     = unit_z[MOD_WIDTH-1:0];
            mul_b_in   = mul_b_ff << 1;
            bit_cnt_in = bit_cnt_ff - BW'(1);
         end
         ST_MUL_END: begin
            case (mul_op_ff)
               MUL_PROD: begin
                  prod_in = acc_ff;
                  exp_in  = exp_ff >> 1;
                  // square the base only if exponent bits remain
                  acc_in     = '0;
                  mul_a_in   = base_ff;
                  mul_b_in   = base_ff;
                  bit_cnt_in = BW'(MOD_WIDTH - 1);
                  mul_op_in  = MUL_BASE;
               end
               MUL_BASE: base_in = acc_ff;
               MUL_SQ: begin
                  prod_in = acc_ff;
                  if (acc_ff == n_minus1) begin
                     prime_in = 1'b1;
                  end else if (few_sq) begin
                     prime_in = 1'b0;
                  end else begin
                     r_in       = r_ff - RW'(1);
                     acc_in     = '0;
                     mul_a_in   = acc_ff;
                     mul_b_in   = acc_ff;
                     bit_cnt_in = BW'(MOD_WIDTH - 1);
                     mul_op_in  = MUL_SQ;
                  end
               end
               default: prime_in = 1'b0;
            endcase
         end
         ST_XCHECK: begin
            if (prod_ff == MOD_WIDTH'(1) || prod_ff == n_minus1) begin
               prime_in = 1'b1;
            end else if (few_sq) begin
               prime_in = 1'b0;
            end else begin
               r_in       = r_ff - RW'(1);
               acc_in     = '0;
               mul_a_in   = prod_ff;
               mul_b_in   = prod_ff;
               bit_cnt_in = BW'(MOD_WIDTH - 1);
               mul_op_in  = MUL_SQ;
            end
         end
         ST_EMIT: begin
            if (emit_free) begin
               rsp_residue_in = n_ff;
               rsp_prime_in   = prime_ff;
               rsp_valid_in   = 1'b1;
            end
         end
         default: begin
            rsp_prime_in = rsp_prime_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MODULUS_RESET[MOD_WIDTH-1:0];
         resid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
         resid_ff     <= resid_in;
      end
      digit_ff       <= digit_in;
      last_ff        <= last_in;
      val_ff         <= val_in;
      red_cnt_ff     <= red_cnt_in;
      n_ff           <= n_in;
      exp_ff         <= exp_in;
      r_ff           <= r_in;
      base_ff        <= base_in;
      prod_ff        <= prod_in;
      prime_ff       <= prime_in;
      acc_ff         <= acc_in;
      mul_a_ff       <= mul_a_in;
      mul_b_ff       <= mul_b_in;
      bit_cnt_ff     <= bit_cnt_in;
      mul_op_ff      <= mul_op_in;
      rsp_residue_ff <= rsp_residue_in;
      rsp_prime_ff   <= rsp_prime_in;
   end

   // multiplier operands stay reduced below the test value
   a_mul_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_DBL || state_ff == ST_MUL_ADD) |->
         (acc_ff < n_ff && mul_a_ff < n_ff))
      else $error("multiplier operand not reduced");

   // the digit step starts from a residue below the modulus
   a_load_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (resid_ff < nm))
      else $error("residue out of range at digit load");

   // five compare-subtract steps leave a fully reduced value
   a_reduce_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE && red_cnt_ff == '0) |-> (unit_z < VW'(nm)))
      else $error("digit reduction incomplete");

   // a loaded result is valid and never calls an even value above two prime
   a_result_sane: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && emit_free) |=>
         (rsp_valid_ff && (!rsp_prime_ff || rsp_residue_ff[0]
                           || rsp_residue_ff == MOD_WIDTH'(2))))
      else $error("bad result loaded");

endmodule

[verif/tb_decimal_residue_prime_test_unit.sv]
// testbench for the decimal residue prime test unit: random digit streams against a predictor
`timescale 1ns / 1ps

module tb_decimal_residue_prime_test_unit;
   import drpt_pkg::*;

   // no-accept watchdog: the limit is meant to cover the slowest test
   // plus result-side stalls
   localparam int WATCHDOG_LIMIT  = 40000;
   // quiet cycles after the last result before touching the modulus:
   // one digit beat plus a full fold of the stored residue
   localparam int SETTLE_CYCLES   = 64;
   localparam int IDLE_PCT        = 19;
   localparam int PHASE_COUNT     = 16;
   localparam int BEATS_PER_PHASE = 66;
   localparam int STEADY_PHASE    = 6;

   typedef struct packed {
      logic [RESIDUE_W-1:0] residue;
      logic                 is_prime;
   } verdict_type;

   // running residue and verdict predictor with its queue of verdicts still owed
   class residue_verdict_board;
      logic [CSR_W-1:0]     modulus;
      logic [RESIDUE_W-1:0] running;
      verdict_type          verdicts_due[$];
      int                   errors;

      function new();
         modulus = MODULUS_RESET;
         running = '0;
         errors  = 0;
      endfunction

      function void set_modulus(logic [CSR_W-1:0] value);
         modulus = value;
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction

      // base-2 strong probable-prime check; 64-bit products keep it exact
      function logic strong_base2_verdict(logic [RESIDUE_W-1:0] n);
         logic [63:0]          wide_n;
         logic [63:0]          base;
         logic [63:0]          acc;
         logic [RESIDUE_W-1:0] odd_part;
         int                   twos;
         if (n <= 1 || n == 4) return 1'b0;
         if (n <= 3) return 1'b1;
         wide_n   = {32'd0, n};
         odd_part = n - 1;
         twos     = 0;
         while (!odd_part[0]) begin
            odd_part = odd_part >> 1;
            twos++;
         end
         base = 64'd2 % wide_n;
         acc  = 64'd1;
         while (odd_part != 0) begin
            if (odd_part[0]) acc = (acc * base) % wide_n;
            odd_part = odd_part >> 1;
            base     = (base * base) % wide_n;
         end
         if (acc == 64'd1 || acc == wide_n - 64'd1) return 1'b1;
         for (int i = 1; i < twos; i++) begin
            acc = (acc * acc) % wide_n;
            if (acc == wide_n - 64'd1) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_digit(logic [DIGIT_W-1:0] digit, logic last);
         logic [63:0] divisor;
         logic [63:0] folded;
         verdict_type v;
         divisor = (modulus == '0) ? 64'd1 : {32'd0, modulus};
         folded  = ({32'd0, running} * 64'd10 + {60'd0, digit}) % divisor;
         running = folded[RESIDUE_W-1:0];
         if (last) begin
            v.residue  = running;
            v.is_prime = strong_base2_verdict(running);
            verdicts_due.push_back(v);
            running = '0;
         end
      endfunction

      function void check_result(logic [RESIDUE_W-1:0] residue, logic is_prime);
         verdict_type want;
         if (verdicts_due.size() == 0) begin
            $error("unexpected result beat: residue %0d is_prime %0d", residue, is_prime);
            errors++;
            return;
         end
         want = verdicts_due.pop_front();
         if (residue !== want.residue) begin
            $error("residue: expected %0d, actual %0d", want.residue, residue);
            errors++;
         end
         if (is_prime !== want.is_prime) begin
            $error("is_prime: expected %0d, actual %0d (residue %0d)",
                   want.is_prime, is_prime, want.residue);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   drpt_req_if req_bus ();
   drpt_rsp_if rsp_bus ();
   drpt_csr_if csr_bus ();

   residue_verdict_board board;
   int   beats_sent;
   int   quiet_cycles;
   logic progress;
   // set for one whole phase so both sides run back to back for a while
   logic steady;

   decimal_residue_prime_test_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side back-pressure: random stalls except in the steady phase
   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // sample every handshake at the edge it completes on; the block's own
   // updates at this edge are not visible yet, so the order is fixed
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         progress = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            board.note_digit(req_bus.digit, req_bus.last);
            progress = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            board.check_result(rsp_bus.residue, rsp_bus.is_prime);
            progress = 1'b1;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            board.set_modulus(csr_bus.data);
            progress = 1'b1;
         end
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // one digit beat; random idle cycles ahead of it outside the steady phase
   task automatic send_beat(input logic [DIGIT_W-1:0] digit, input logic last);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid <= 1'b1;
      req_bus.digit <= digit;
      req_bus.last  <= last;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
   endtask

   // a known value, most significant digit first, last on the final digit
   task automatic send_value(input longint unsigned value);
      logic [DIGIT_W-1:0] digits[$];
      longint unsigned    rest;
      rest = value;
      do begin
         digits.push_front(DIGIT_W'(rest % 10));
         rest = rest / 10;
      end while (rest != 0);
      foreach (digits[i]) send_beat(digits[i], i == digits.size() - 1);
   endtask

   // random number: mostly short, sometimes long; a few digits above nine
   task automatic send_random_number();
      int                 length;
      logic [DIGIT_W-1:0] digit;
      length = ($urandom_range(9) == 0) ? $urandom_range(14, 9) : $urandom_range(8, 1);
      for (int i = 0; i < length; i++) begin
         digit = ($urandom_range(99) < 6) ? DIGIT_W'($urandom_range(15, 10))
                                          : DIGIT_W'($urandom_range(9, 0));
         send_beat(digit, i == length - 1);
      end
   endtask

   // drop valid, let every owed verdict arrive, then let the block go quiet
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      // wait so the beat accepted at the current edge is already noted
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [CSR_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // phase moduli: degenerate ones first, then small and extreme ones, then random sizes, the reset modulus last
   function automatic logic [CSR_W-1:0] pick_modulus(input int phase_idx);
      case (phase_idx)
         0:            return '0;            // behaves as one
         1:            return 32'd1;
         2:            return 32'd2;
         3:            return 32'd3;
         4:            return 32'd97;
         5:            return '1;
         STEADY_PHASE: return CSR_W'($urandom_range(60000, 1000));
         PHASE_COUNT - 1: return MODULUS_RESET;
         default: begin
            case ($urandom_range(2))
               0:       return CSR_W'($urandom_range(5000, 5));
               1:       return CSR_W'($urandom_range(24'hFFFFFF, 32'h10000));
               default: return $urandom() | 32'h8000_0000;
            endcase
         end
      endcase
   endfunction

   initial begin
      logic [CSR_W-1:0] phase_modulus;
      int               quota;
      board         = new();
      beats_sent    = 0;
      steady        = 1'b0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.digit <= '0;
      req_bus.last  <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed numbers under the reset modulus: the settled-at-once
      // residues, digits above nine, a base-2 strong pseudoprime, a prime
      // and the modulus minus one
      send_value(0);
      send_value(1);
      send_value(2);
      send_value(3);
      send_value(4);
      send_beat(4'd15, 1'b0);
      send_beat(4'd15, 1'b0);
      send_beat(4'd9, 1'b1);
      send_value(2047);
      send_value(97);
      send_value(1000000006);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         phase_modulus = pick_modulus(p);
         wait_drained();
         write_modulus(phase_modulus);
         steady = (p == STEADY_PHASE);
         if (phase_modulus == '1) begin
            // large residues: strong pseudoprime, biggest 32-bit prime, even value
            send_value(64'd3215031751);
            send_value(64'd4294967291);
            send_value(64'd4294967294);
         end
         quota = beats_sent + BEATS_PER_PHASE;
         while (beats_sent < quota) send_random_number();
      end
      steady = 1'b0;

      wait_drained();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[decimal_residue_prime_test_unit.f]
rtl/drpt_pkg.sv
rtl/drpt_if.sv
rtl/drpt_addmod.sv
rtl/decimal_residue_prime_test_unit.sv
verif/tb_decimal_residue_prime_test_unit.sv
